FILE: rtl/plid_pkg.sv
package plid_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int CNT_W         = 7;
    localparam int DATA_W        = 32;

    typedef enum logic [2:0] {
        K_INS_FRONT = 3'd0,
        K_INS_END   = 3'd1,
        K_INS_POS   = 3'd2,
        K_DEL_FIRST = 3'd3,
        K_DEL_LAST  = 3'd4,
        K_DEL_POS   = 3'd5,
        K_DUMP      = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BOUND = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INS,
        CELL_DEL,
        CELL_ROT
    } t_cell_op;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } t_state;

    typedef struct packed {
        t_kind               kind;
        logic [6:0]          position;
        logic signed [31:0]  value;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic signed [31:0]  element;
        logic [6:0]          length;
        logic                last_result;
    } t_resp;

    // broadcast to every cell of the chain
    typedef struct packed {
        t_cell_op            op;
        logic [CNT_W-1:0]    slot;
        logic [CNT_W-1:0]    tail;
        logic [DATA_W-1:0]   value;
    } t_cell_cmd;

endpackage

FILE: rtl/plid_cell.sv
module plid_cell #(
    parameter int IDX = 0
) (
    input  logic                        i_clk,
    input  plid_pkg::t_cell_cmd         i_cmd,
    input  logic [plid_pkg::DATA_W-1:0] i_left,
    input  logic [plid_pkg::DATA_W-1:0] i_right,
    input  logic [plid_pkg::DATA_W-1:0] i_wrap,
    output logic [plid_pkg::DATA_W-1:0] o_data
);

    localparam logic [plid_pkg::CNT_W-1:0] MY_IDX = plid_pkg::CNT_W'(IDX);

    logic [plid_pkg::DATA_W-1:0] r_data;
    logic [plid_pkg::DATA_W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        unique case (i_cmd.op)
            plid_pkg::CELL_INS: begin
                if (MY_IDX > i_cmd.slot) begin
                    n_data = i_left;
                end else if (MY_IDX == i_cmd.slot) begin
                    n_data = i_cmd.value;
                end
            end
            plid_pkg::CELL_DEL: begin
                if (MY_IDX >= i_cmd.slot) begin
                    n_data = i_right;
                end
            end
            plid_pkg::CELL_ROT: begin
                // rotate the occupied part left; the tail picks up the head
                if (MY_IDX < i_cmd.tail) begin
                    n_data = i_right;
                end else if (MY_IDX == i_cmd.tail) begin
                    n_data = i_wrap;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

FILE: rtl/plid_ctrl.sv
module plid_ctrl #(
    parameter int DEPTH = plid_pkg::DEPTH_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  plid_pkg::t_req              i_req,
    input  logic [plid_pkg::DATA_W-1:0] i_head,
    output logic                        o_busy,
    output plid_pkg::t_cell_cmd         o_cmd,
    output logic                        o_strobe,
    output plid_pkg::t_resp             o_resp
);

    localparam logic [plid_pkg::CNT_W-1:0] FULL_CNT = plid_pkg::CNT_W'(DEPTH);

    plid_pkg::t_state             r_state, n_state;
    logic [plid_pkg::CNT_W-1:0]   r_count, n_count;
    logic [plid_pkg::CNT_W-1:0]   r_idx, n_idx;
    logic                         r_strobe, n_strobe;
    plid_pkg::t_resp              r_resp, n_resp;

    logic                         w_accept;
    logic [plid_pkg::CNT_W:0]     w_pos_ext;
    logic [plid_pkg::CNT_W:0]     w_cnt_p1;

    assign w_accept  = i_start && (r_state == plid_pkg::S_IDLE);
    assign w_pos_ext = {1'b0, i_req.position};
    assign w_cnt_p1  = {1'b0, r_count} + {{plid_pkg::CNT_W{1'b0}}, 1'b1};

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_strobe = 1'b0;
        n_resp   = r_resp;
        o_cmd.op    = plid_pkg::CELL_HOLD;
        o_cmd.slot  = '0;
        o_cmd.tail  = r_count - plid_pkg::CNT_W'(1);
        o_cmd.value = i_req.value;

        unique case (r_state)
            plid_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_strobe           = 1'b1;
                    n_resp.status      = plid_pkg::ST_OK;
                    n_resp.element     = '0;
                    n_resp.last_result = 1'b1;
                    case (i_req.kind)
                        plid_pkg::K_INS_FRONT, plid_pkg::K_INS_END,
                        plid_pkg::K_INS_POS: begin
                            if (r_count >= FULL_CNT) begin
                                n_resp.status = plid_pkg::ST_FULL;
                            end else if (i_req.kind == plid_pkg::K_INS_FRONT) begin
                                o_cmd.op = plid_pkg::CELL_INS;
                            end else if (i_req.kind == plid_pkg::K_INS_END) begin
                                o_cmd.op   = plid_pkg::CELL_INS;
                                o_cmd.slot = r_count;
                            end else if (i_req.position == '0 || w_pos_ext > w_cnt_p1) begin
                                n_resp.status = plid_pkg::ST_BOUND;
                            end else begin
                                o_cmd.op   = plid_pkg::CELL_INS;
                                o_cmd.slot = i_req.position - plid_pkg::CNT_W'(1);
                            end
                            if (o_cmd.op == plid_pkg::CELL_INS) begin
                                n_count = r_count + plid_pkg::CNT_W'(1);
                            end
                        end
                        plid_pkg::K_DEL_FIRST, plid_pkg::K_DEL_LAST,
                        plid_pkg::K_DEL_POS: begin
                            if (r_count == '0) begin
                                n_resp.status = plid_pkg::ST_EMPTY;
                            end else if (i_req.kind == plid_pkg::K_DEL_FIRST) begin
                                o_cmd.op = plid_pkg::CELL_DEL;
                            end else if (i_req.kind == plid_pkg::K_DEL_LAST) begin
                                o_cmd.op   = plid_pkg::CELL_DEL;
                                o_cmd.slot = r_count - plid_pkg::CNT_W'(1);
                            end else if (i_req.position == '0 || i_req.position > r_count) begin
                                n_resp.status = plid_pkg::ST_BOUND;
                            end else begin
                                o_cmd.op   = plid_pkg::CELL_DEL;
                                o_cmd.slot = i_req.position - plid_pkg::CNT_W'(1);
                            end
                            if (o_cmd.op == plid_pkg::CELL_DEL) begin
                                n_count = r_count - plid_pkg::CNT_W'(1);
                            end
                        end
                        plid_pkg::K_DUMP: begin
                            if (r_count == '0) begin
                                n_resp.status = plid_pkg::ST_EMPTY;
                            end else begin
                                // results come from the dump state instead
                                n_strobe = 1'b0;
                                n_state  = plid_pkg::S_DUMP;
                                n_idx    = '0;
                            end
                        end
                        default: ;
                    endcase
                    n_resp.length = n_count;
                end
            end
            plid_pkg::S_DUMP: begin
                o_cmd.op           = plid_pkg::CELL_ROT;
                n_strobe           = 1'b1;
                n_resp.status      = plid_pkg::ST_OK;
                n_resp.element     = i_head;
                n_resp.length      = r_count;
                n_resp.last_result = (r_idx == o_cmd.tail);
                n_idx              = r_idx + plid_pkg::CNT_W'(1);
                if (r_idx == o_cmd.tail) begin
                    n_state = plid_pkg::S_IDLE;
                end
            end
            default: n_state = plid_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= plid_pkg::S_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_resp <= n_resp;
    end

    assign o_busy   = (r_state == plid_pkg::S_DUMP);
    assign o_strobe = r_strobe;
    assign o_resp   = r_resp;

endmodule

FILE: rtl/positional_list_insert_delete_top.sv
// Channel   Signals                      Accepted when
// request   start, busy, i_req           rising edge with start high and busy low
// result    o_strobe, o_resp             every cycle o_strobe is high (no stall)
//
// Each cell of the chain holds one list entry; insert and delete shift every
// entry behind the slot together, and the result of such a request shows in the
// cycle after its acceptance.
// A dump moves the controller from idle to its dump state, in which the
// occupied cells rotate left once a cycle and the head cell feeds one result
// per cycle until every entry has been given; busy is high in the dump state,
// and the first result passes the state register and then the result registers.
// Reset clears the fill count and the controller; entry contents are not reset.
// The receiver cannot stall: results are registered and never held.
module positional_list_insert_delete_top #(
    parameter int DEPTH = plid_pkg::DEPTH_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  plid_pkg::t_req  i_req,
    output logic            busy,
    output logic            o_strobe,
    output plid_pkg::t_resp o_resp
);

    plid_pkg::t_cell_cmd         w_cmd;
    logic [plid_pkg::DATA_W-1:0] w_data [DEPTH];

    plid_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_req    (i_req),
        .i_head   (w_data[0]),
        .o_busy   (busy),
        .o_cmd    (w_cmd),
        .o_strobe (o_strobe),
        .o_resp   (o_resp)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [plid_pkg::DATA_W-1:0] w_left;
        logic [plid_pkg::DATA_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end
        plid_cell #(
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .i_wrap  (w_data[0]),
            .o_data  (w_data[g])
        );
    end

    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_resp.status == plid_pkg::ST_FULL)
            |-> (o_resp.length == plid_pkg::CNT_W'(DEPTH)))
        else $error("full status with length below depth");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req.kind != plid_pkg::K_DUMP)
            |=> (o_strobe && o_resp.last_result))
        else $error("non-dump request did not give a single final result");

    a_dump_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_resp.last_result) |-> busy)
        else $error("dump result pending but controller not busy");

    a_empty_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_resp.status == plid_pkg::ST_EMPTY) |-> (o_resp.length == '0))
        else $error("empty status with nonzero length");

endmodule

FILE: tb/sv/positional_list_insert_delete_top_tb.sv
module positional_list_insert_delete_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH  = plid_pkg::DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_LIMIT = 4000;
    localparam int TAIL_CYCLES = 2 * LIST_DEPTH + 8;

    logic            i_clk = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            start = 1'b0;
    plid_pkg::t_req  i_req = '0;
    logic            busy;
    logic            o_strobe;
    plid_pkg::t_resp o_resp;

    // mirror of the list contents, front first
    logic signed [31:0] held_values[$];
    plid_pkg::t_resp    pending_resps[$];
    int                 mismatch_count = 0;
    int                 cycle_count = 0;
    bit                 gaps_on = 1'b1;

    positional_list_insert_delete_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_req   (i_req),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_resp  (o_resp)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic plid_pkg::t_req make_req(plid_pkg::t_kind kind, int pos,
                                                logic [31:0] val);
        plid_pkg::t_req r;
        r.kind     = kind;
        r.position = pos[6:0];
        r.value    = val;
        return r;
    endfunction

    function automatic plid_pkg::t_resp make_resp(plid_pkg::t_status st,
                                                  logic [31:0] elem, logic last);
        plid_pkg::t_resp p;
        p.status      = st;
        p.element     = elem;
        p.length      = 7'(held_values.size());
        p.last_result = last;
        return p;
    endfunction

    // update the mirror for one accepted request and queue its results
    function automatic void apply_list_op(plid_pkg::t_req r);
        int count;
        int pos;
        plid_pkg::t_status st;
        count = held_values.size();
        pos   = r.position;
        st    = plid_pkg::ST_OK;
        case (r.kind)
            plid_pkg::K_INS_FRONT, plid_pkg::K_INS_END, plid_pkg::K_INS_POS: begin
                if (count >= LIST_DEPTH) begin
                    st = plid_pkg::ST_FULL;
                end else if (r.kind == plid_pkg::K_INS_FRONT) begin
                    held_values.push_front(r.value);
                end else if (r.kind == plid_pkg::K_INS_END) begin
                    held_values.push_back(r.value);
                end else if (pos < 1 || pos > count + 1) begin
                    st = plid_pkg::ST_BOUND;
                end else begin
                    held_values.insert(pos - 1, r.value);
                end
            end
            plid_pkg::K_DEL_FIRST, plid_pkg::K_DEL_LAST, plid_pkg::K_DEL_POS: begin
                if (count == 0) begin
                    st = plid_pkg::ST_EMPTY;
                end else if (r.kind == plid_pkg::K_DEL_FIRST) begin
                    held_values.delete(0);
                end else if (r.kind == plid_pkg::K_DEL_LAST) begin
                    held_values.delete(count - 1);
                end else if (pos < 1 || pos > count) begin
                    st = plid_pkg::ST_BOUND;
                end else begin
                    held_values.delete(pos - 1);
                end
            end
            plid_pkg::K_DUMP: begin
                if (count == 0) begin
                    st = plid_pkg::ST_EMPTY;
                end else begin
                    for (int i = 0; i < count; i++)
                        pending_resps.push_back(make_resp(plid_pkg::ST_OK, held_values[i],
                                                          i == count - 1));
                    return;
                end
            end
            default: ;
        endcase
        pending_resps.push_back(make_resp(st, '0, 1'b1));
    endfunction

    always @(posedge i_clk) begin
        plid_pkg::t_resp want;
        if (i_rst_n && o_strobe) begin
            if (pending_resps.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: status %0d element %0d length %0d last %0b",
                             o_resp.status, o_resp.element, o_resp.length,
                             o_resp.last_result);
            end else begin
                want = pending_resps.pop_front();
                if (o_resp.status !== want.status || o_resp.element !== want.element ||
                    o_resp.length !== want.length ||
                    o_resp.last_result !== want.last_result) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: status %0d/%0d element %0d/%0d ",
                                  "length %0d/%0d last %0b/%0b (expected/actual)"},
                                 want.status, o_resp.status, want.element, o_resp.element,
                                 want.length, o_resp.length, want.last_result,
                                 o_resp.last_result);
                end
            end
        end
    end

    // one request; start stays high across back-to-back requests
    task automatic send_request(plid_pkg::t_req r);
        @(negedge i_clk);
        if (gaps_on) begin
            while ($urandom_range(0, 99) < 15) begin
                start <= 1'b0;
                @(negedge i_clk);
            end
        end
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        apply_list_op(r);
    endtask

    task automatic wait_drained();
        int waited;
        waited = 0;
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_resps.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    task automatic test_empty_list();
        send_request(make_req(plid_pkg::K_DUMP, 0, 32'h0));
        send_request(make_req(plid_pkg::K_DEL_FIRST, 0, 32'hFFFF_FFFF));
        send_request(make_req(plid_pkg::K_DEL_LAST, 127, 32'h0));
        send_request(make_req(plid_pkg::K_DEL_POS, 1, 32'h0));
        send_request(make_req(plid_pkg::K_INS_POS, 0, 32'h1234_5678));
        send_request(make_req(plid_pkg::K_INS_POS, 2, 32'h1234_5678));
        send_request(make_req(plid_pkg::t_kind'(3'd7), 127, 32'hFFFF_FFFF));
    endtask

    task automatic test_fill_to_full();
        send_request(make_req(plid_pkg::K_INS_FRONT, 0, 32'h8000_0000));
        send_request(make_req(plid_pkg::K_INS_END, 127, 32'h7FFF_FFFF));
        send_request(make_req(plid_pkg::K_INS_POS, 2, 32'hFFFF_FFFF));
        send_request(make_req(plid_pkg::K_INS_POS, 1, 32'h0));
        send_request(make_req(plid_pkg::K_INS_POS, 5, 32'h5555_5555));   // count + 1
        send_request(make_req(plid_pkg::K_INS_POS, 7, 32'hAAAA_AAAA));   // past count + 1
        while (held_values.size() < LIST_DEPTH)
            send_request(make_req(plid_pkg::K_INS_END, $urandom_range(0, 127), $urandom()));
        send_request(make_req(plid_pkg::K_INS_FRONT, 0, 32'h1));
        send_request(make_req(plid_pkg::K_INS_END, 0, 32'h2));
        // full wins over a bad position
        send_request(make_req(plid_pkg::K_INS_POS, 127, 32'h3));
        send_request(make_req(plid_pkg::K_INS_POS, 1, 32'h4));
        send_request(make_req(plid_pkg::K_DUMP, 0, 32'h0));
    endtask

    task automatic test_delete_cases();
        send_request(make_req(plid_pkg::K_DEL_POS, 0, 32'h0));
        send_request(make_req(plid_pkg::K_DEL_POS, LIST_DEPTH + 1, 32'h0));
        send_request(make_req(plid_pkg::K_DEL_POS, 127, 32'h0));
        send_request(make_req(plid_pkg::K_DEL_POS, LIST_DEPTH, 32'h0));
        send_request(make_req(plid_pkg::K_DEL_POS, 1, 32'h0));
        send_request(make_req(plid_pkg::K_DEL_FIRST, 0, 32'h0));
        send_request(make_req(plid_pkg::K_DEL_LAST, 0, 32'h0));
        send_request(make_req(plid_pkg::t_kind'(3'd7), 0, 32'h0));
        send_request(make_req(plid_pkg::K_DUMP, 127, 32'hFFFF_FFFF));
        wait_drained();
    endtask

    // ins_pct steers the fill level: high fills the list, low drains it
    task automatic test_random_ops(int num, int ins_pct);
        int roll;
        int count;
        int pos;
        plid_pkg::t_kind kind;
        logic [31:0] val;
        for (int n = 0; n < num; n++) begin
            count = held_values.size();
            roll  = $urandom_range(0, 99);
            if (roll < ins_pct)
                kind = plid_pkg::t_kind'($urandom_range(0, 2));
            else if (roll < 90)
                kind = plid_pkg::t_kind'($urandom_range(3, 5));
            else if (roll < 97)
                kind = plid_pkg::K_DUMP;
            else
                kind = plid_pkg::t_kind'(3'd7);
            if ($urandom_range(0, 99) < 20)
                pos = $urandom_range(0, 127);
            else if (kind == plid_pkg::K_INS_POS)
                pos = $urandom_range(1, count + 1);
            else
                pos = $urandom_range(1, count > 0 ? count : 1);
            case ($urandom_range(0, 9))
                0:       val = 32'h8000_0000;
                1:       val = 32'h7FFF_FFFF;
                2:       val = 32'hFFFF_FFFF;
                3:       val = 32'h0;
                default: val = $urandom();
            endcase
            send_request(make_req(kind, pos, val));
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_list();
        test_fill_to_full();
        test_delete_cases();

        gaps_on = 1'b0;
        test_random_ops(200, 45);
        gaps_on = 1'b1;
        test_random_ops(100, 70);
        wait_drained();
        test_random_ops(100, 20);
        test_random_ops(100, 45);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_resps.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
